// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, prop)
`endif

`endif

// ----- rtl/pic_pkg.sv -----
`default_nettype none
package pic_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  localparam logic [2:0] REG_PRIO   = 3'd0;
  localparam logic [2:0] REG_PEND   = 3'd1;
  localparam logic [2:0] REG_ENABLE = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_CLAIM  = 3'd4;

  typedef struct packed {
    logic load;
    logic apply;
    logic cap_prio;
    logic scan;
    logic finish;
  } pic_ctrl_t;

  typedef struct packed {
    logic scan_last;
  } pic_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pic_ram.sv -----
`default_nettype none
module pic_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/pic_ctrl.sv -----
`default_nettype none
module pic_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pic_pkg::pic_stat_t stat,
  output pic_pkg::pic_ctrl_t     ctrl,
  output logic                   busy,
  output logic                   done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP   = 3'd1;
  localparam logic [2:0] ST_PRD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_LAST = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_OP;
        end
      end
      ST_OP:   state_next = ST_PRD;
      ST_PRD:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load     = (state == ST_IDLE) && start;
    ctrl.apply    = (state == ST_OP);
    ctrl.cap_prio = (state == ST_PRD);
    ctrl.scan     = (state == ST_SCAN);
    ctrl.finish   = (state == ST_FIN);
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pic_dp.sv -----
`default_nettype none
module pic_dp #(
  parameter int NUM_SOURCES = 32,
  parameter int PRIO_BITS   = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pic_pkg::pic_ctrl_t ctrl,
  output pic_pkg::pic_stat_t      stat,
  input  wire logic [1:0]         command,
  input  wire logic [2:0]         reg_select,
  input  wire logic [4:0]         source_index,
  input  wire logic [31:0]        write_data,
  input  wire logic [31:0]        irq_lines,
  output logic [31:0]             read_data,
  output logic                    irq_request
);

  localparam int IDX_W = $clog2(NUM_SOURCES);
  localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

  logic [1:0]             cmd_q;
  logic [2:0]             sel_q;
  logic [4:0]             idx_q;
  logic [31:0]            wd_q;
  logic [31:0]            lines_q;

  logic [NUM_SOURCES-1:0] pending;
  logic [NUM_SOURCES-1:0] enable;
  logic [NUM_SOURCES-1:0] in_service;
  logic [NUM_SOURCES-1:0] prio_vld;
  logic [PRIO_BITS-1:0]   threshold;
  logic [PRIO_BITS-1:0]   prio_rd;

  logic [IDX_W-1:0]       cnt;
  logic                   cmp_valid;
  logic [IDX_W-1:0]       cmp_id;
  logic                   found;
  logic                   second;
  logic [IDX_W-1:0]       best_id;
  logic [PRIO_BITS-1:0]   best_prio;

  logic                   idx_ok;
  logic [IDX_W-1:0]       idx_a;
  logic [IDX_W-1:0]       wd_a;
  logic                   is_rd;
  logic                   is_wr;
  logic                   claim;
  logic                   cpl_ok;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [PRIO_BITS-1:0]   ram_rd;
  logic [NUM_SOURCES-1:0] elig;
  logic [PRIO_BITS-1:0]   cand_prio;
  logic                   cand_ok;
  logic                   cand_better;
  logic [31:0]            rd_value;

  assign idx_a  = idx_q[IDX_W-1:0];
  assign wd_a   = wd_q[IDX_W-1:0];
  assign idx_ok = (idx_q != 5'd0) && (32'(idx_q) < 32'(NUM_SOURCES));
  assign is_rd  = (cmd_q == pic_pkg::CMD_READ);
  assign is_wr  = (cmd_q == pic_pkg::CMD_WRITE);
  assign claim  = is_rd && (sel_q == pic_pkg::REG_CLAIM);
  assign cpl_ok = (wd_q < 32'(NUM_SOURCES)) && enable[wd_a];

  assign ram_we    = ctrl.apply && is_wr && (sel_q == pic_pkg::REG_PRIO) && idx_ok;
  assign ram_raddr = ctrl.scan ? cnt : idx_a;

  pic_ram #(
    .WIDTH (PRIO_BITS),
    .DEPTH (NUM_SOURCES)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_a),
    .wdata (wd_q[PRIO_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  assign elig        = pending & enable;
  assign cand_prio   = prio_vld[cmp_id] ? ram_rd : '0;
  assign cand_ok     = cmp_valid && elig[cmp_id] && (cand_prio > threshold);
  assign cand_better = !found || (cand_prio > best_prio);

  assign stat.scan_last = (cnt == IDX_W'(NUM_SOURCES - 1));

  always_comb begin
    rd_value = '0;
    if (is_rd) begin
      unique case (sel_q)
        pic_pkg::REG_PRIO:   rd_value = 32'(prio_rd);
        pic_pkg::REG_PEND:   rd_value = 32'(pending);
        pic_pkg::REG_ENABLE: rd_value = 32'(enable);
        pic_pkg::REG_THRESH: rd_value = 32'(threshold);
        pic_pkg::REG_CLAIM:  rd_value = found ? 32'(best_id) : '0;
        default:             rd_value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      enable     <= '0;
      in_service <= '0;
      prio_vld   <= '0;
      threshold  <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      cmp_valid <= ctrl.scan;
      if (ctrl.apply) begin
        if (cmd_q == pic_pkg::CMD_SAMPLE) begin
          pending <= pending | (lines_q[NUM_SOURCES-1:0] & SRC_MASK & ~in_service);
        end else if (is_wr) begin
          unique case (sel_q)
            pic_pkg::REG_PRIO: begin
              if (idx_ok) begin
                prio_vld[idx_a] <= 1'b1;
              end
            end
            pic_pkg::REG_ENABLE: enable    <= wd_q[NUM_SOURCES-1:0] & SRC_MASK;
            pic_pkg::REG_THRESH: threshold <= wd_q[PRIO_BITS-1:0];
            pic_pkg::REG_CLAIM: begin
              if (cpl_ok) begin
                in_service[wd_a] <= 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      if (ctrl.finish && claim && found) begin
        pending[best_id]    <= 1'b0;
        in_service[best_id] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= command;
      sel_q   <= reg_select;
      idx_q   <= source_index;
      wd_q    <= write_data;
      lines_q <= irq_lines;
    end
    if (ctrl.apply) begin
      cnt    <= IDX_W'(1);
      found  <= 1'b0;
      second <= 1'b0;
    end
    if (ctrl.cap_prio) begin
      prio_rd <= (idx_ok && prio_vld[idx_a]) ? ram_rd : '0;
    end
    if (ctrl.scan) begin
      cnt    <= cnt + IDX_W'(1);
      cmp_id <= cnt;
    end
    if (cand_ok) begin
      if (cand_better) begin
        best_id   <= cmp_id;
        best_prio <= cand_prio;
      end
      if (found) begin
        second <= 1'b1;
      end
      found <= 1'b1;
    end
    if (ctrl.finish) begin
      read_data   <= rd_value;
      irq_request <= claim ? second : found;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/platform_interrupt_controller_top.sv -----
// Single-context platform interrupt controller.
// Command channel: an item (command, reg_select, source_index, write_data,
// irq_lines) is taken at a rising edge with start high and busy low.
// Commands: sample the irq_lines, read a register, write a register.
// A read of the claim/complete register returns the winning source and
// moves it from pending to in service; a write there completes a source.
// Result channel: read_data and irq_request are shown for one cycle with
// done high; read_data is 0 for samples and writes.
// Every item runs an arbitration scan over the priority RAM, one source
// per cycle, and done rises in the same cycle that busy falls.
// A new item can be taken in the done cycle.
// The receiver cannot stall; a result not taken in its done cycle is lost.
// Reset clears the priority valid bits, pending, enable, threshold and
// in-service state at once; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module platform_interrupt_controller_top #(
  parameter int NUM_SOURCES = 32,
  parameter int PRIO_BITS   = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [2:0]  reg_select,
  input  wire logic [4:0]  source_index,
  input  wire logic [31:0] write_data,
  input  wire logic [31:0] irq_lines,
  output logic             done,
  output logic [31:0]      read_data,
  output logic             irq_request
);

  pic_pkg::pic_ctrl_t ctrl;
  pic_pkg::pic_stat_t stat;

  pic_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  pic_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .reg_select   (reg_select),
    .source_index (source_index),
    .write_data   (write_data),
    .irq_lines    (irq_lines),
    .read_data    (read_data),
    .irq_request  (irq_request)
  );

  `ASSERT_CLK(a_done_when_idle, clk, rst, done |-> !busy)
  `ASSERT_CLK(a_accept_goes_busy, clk, rst, (start && !busy) |=> (busy && !done))
  `ASSERT_CLK(a_done_single, clk, rst, done |=> !done)
  `ASSERT_CLK(a_ctrl_exclusive, clk, rst, $onehot0(ctrl))

endmodule
`default_nettype wire
